/* rtl/tcr_pkg.sv */
// Package for the timer with compare and reload: widths, register offsets, opcodes.
// No dependencies.
`timescale 1ns / 1ps
package tcr_pkg;
  localparam int CountWidth = 32;
  localparam int DivCntW = $clog2(CountWidth + 1);

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [7:0] OFF_CR1  = 8'h00;
  localparam logic [7:0] OFF_CR2  = 8'h04;
  localparam logic [7:0] OFF_DIER = 8'h0C;
  localparam logic [7:0] OFF_SR   = 8'h10;
  localparam logic [7:0] OFF_EGR  = 8'h14;
  localparam logic [7:0] OFF_CCMR = 8'h18;
  localparam logic [7:0] OFF_CNT  = 8'h24;
  localparam logic [7:0] OFF_PSC  = 8'h28;
  localparam logic [7:0] OFF_ARR  = 8'h2C;
  localparam logic [7:0] OFF_CCR  = 8'h34;

  // controller -> datapath
  typedef struct packed {
    logic exec;       // apply the held word (tick/read/write), latch result
    logic div_start;  // load divider with the count to wrap
    logic div_step;   // one restoring-division step
    logic div_done;   // end of division, issued with the exec that stores the remainder
  } tcr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_wrap; // held word is a CNT or ARR write
  } tcr_sts_t;

  function automatic logic [31:0] size_mask(input logic [1:0] code);
    logic [31:0] m;
    m = 32'hFFFF_FFFF;
    if (code == 2'd0) m = 32'h0000_00FF;
    else if (code == 2'd1) m = 32'h0000_FFFF;
    return m;
  endfunction
endpackage

/* rtl/tcr_ctrl.sv */
// Controller for the timer: handshake, issue of exec and the modulo sequence.
// Depends on tcr_pkg.
`timescale 1ns / 1ps
module tcr_ctrl import tcr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     load,
  output tcr_cmd_t cmd,
  input  tcr_sts_t sts
);
  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_OUT} state_t;
  state_t state_r, state_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign load      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    unique case (state_r)
      S_IDLE: if (load) state_nxt = S_EXEC;
      S_EXEC: begin
        if (sts.needs_wrap) begin
          cmd.div_start = 1'b1;
          cnt_nxt = DivCntW'(CountWidth);
          state_nxt = S_DIV;
        end else begin
          cmd.exec = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        if (cnt_r != '0) begin
          cmd.div_step = 1'b1;
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          cmd.div_done = 1'b1;
          cmd.exec = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> !in_ready) else $error("accepted while busy");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |=> out_valid_r) else $error("result lost");
  a_one_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !cmd.exec) else $error("double exec");
endmodule

/* rtl/tcr_dp.sv */
// Datapath for the timer: registers, prescaler, counter step, bit-serial modulo.
// Depends on tcr_pkg.
`timescale 1ns / 1ps
module tcr_dp import tcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_reg_offset,
  input  logic [31:0] in_write_data,
  input  logic [1:0]  in_size_code,
  input  tcr_cmd_t    cmd,
  output tcr_sts_t    sts,
  output logic [31:0] out_read_data,
  output logic        out_irq_pulse
);
  localparam int CW = CountWidth;

  logic [1:0]  op_r;
  logic [7:0]  off_r;
  logic [31:0] data_r, mask_r;

  logic [31:0] cr1_r, cr2_r, dier_r, ccmr_r;
  logic [1:0]  sr_r;
  logic [CW-1:0] ccr_r, arr_r, cnt_r;
  logic [15:0] psc_r, ph_r;
  logic armed_r;
  logic [31:0] rd_r;
  logic pulse_r;

  // divider: remainder of dividend by (divisor+1), divisor as CW+1 bits
  logic [CW-1:0] dvd_r;
  logic [CW:0]   rem_r, dvs_r;
  logic [CW:0]   rem_sh;
  logic [CW-1:0] wdata;

  assign wdata = data_r[CW-1:0];
  assign sts.needs_wrap = (op_r == OP_WRITE) && (off_r == OFF_CNT || off_r == OFF_ARR);
  assign rem_sh = {rem_r[CW-1:0], dvd_r[CW-1]};

  always_ff @(posedge clk) begin
    if (load) begin
      op_r <= in_opcode;
      off_r <= in_reg_offset;
      mask_r <= size_mask(in_size_code);
      data_r <= in_write_data & size_mask(in_size_code);
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      if (off_r == OFF_CNT) begin
        dvd_r <= wdata;
        dvs_r <= {1'b0, arr_r} + 1'b1;
      end else begin
        dvd_r <= cnt_r;
        dvs_r <= {1'b0, wdata} + 1'b1;
      end
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[CW-2:0], 1'b0};
      rem_r <= (rem_sh >= dvs_r) ? rem_sh - dvs_r : rem_sh;
    end
  end

  logic [CW-1:0] cnt_nxt, ccr_nxt, arr_nxt, nstep;
  logic [15:0] ph_nxt;
  logic [1:0] sr_nxt;
  logic [31:0] cr1_nxt, dier_nxt, rd_nxt;
  logic hit;

  always_comb begin
    cr1_nxt = cr1_r; cnt_nxt = cnt_r; ccr_nxt = ccr_r; arr_nxt = arr_r;
    dier_nxt = dier_r;
    ph_nxt = ph_r; sr_nxt = sr_r; rd_nxt = '0; hit = 1'b0;
    nstep = (cnt_r >= arr_r) ? '0 : cnt_r + 1'b1;
    unique case (op_r)
      OP_TICK: begin
        if (cr1_r[0]) begin
          if (ph_r >= psc_r) begin
            ph_nxt = '0;
            if (cnt_r >= arr_r) sr_nxt[0] = 1'b1;
            if (arr_r == '0) hit = 1'b1;
            else if (nstep >= cnt_r) hit = (cnt_r < ccr_r) && (ccr_r <= nstep);
            else hit = (ccr_r > cnt_r) || (ccr_r <= nstep);
            if (ccr_r <= arr_r && hit) sr_nxt[1] = 1'b1;
            cnt_nxt = nstep;
          end else begin
            ph_nxt = ph_r + 1'b1;
          end
        end
      end
      OP_READ: begin
        priority case (off_r)
          OFF_CR1:  rd_nxt = cr1_r;
          OFF_CR2:  rd_nxt = cr2_r;
          OFF_DIER: rd_nxt = dier_r;
          OFF_SR:   rd_nxt = {30'd0, sr_r};
          OFF_CCMR: rd_nxt = ccmr_r;
          OFF_CNT:  rd_nxt = 32'(cnt_r);
          OFF_PSC:  rd_nxt = {16'd0, psc_r};
          OFF_ARR:  rd_nxt = 32'(arr_r);
          OFF_CCR:  rd_nxt = 32'(ccr_r);
          default:  rd_nxt = '0;
        endcase
        rd_nxt = rd_nxt & mask_r;
      end
      OP_WRITE: begin
        priority case (off_r)
          OFF_CR1: begin cr1_nxt = data_r; ph_nxt = '0; end
          OFF_DIER: dier_nxt = data_r;
          OFF_SR:  sr_nxt = sr_r & data_r[1:0];
          OFF_EGR: if (data_r[0]) begin cnt_nxt = '0; ph_nxt = '0; end
          OFF_CNT: begin cnt_nxt = rem_r[CW-1:0]; ph_nxt = '0; end
          OFF_PSC: ph_nxt = '0;
          OFF_ARR: begin arr_nxt = wdata; cnt_nxt = rem_r[CW-1:0]; ph_nxt = '0; end
          OFF_CCR: begin ccr_nxt = wdata; sr_nxt[1] = 1'b0; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  logic wr;
  assign wr = cmd.exec && (op_r == OP_WRITE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr1_r <= '0; cr2_r <= '0; dier_r <= '0; ccmr_r <= '0; sr_r <= '0;
      ccr_r <= '0; psc_r <= '0; arr_r <= '1; cnt_r <= '0; ph_r <= '0;
      armed_r <= 1'b0; rd_r <= '0; pulse_r <= 1'b0;
    end else if (cmd.exec) begin
      cr1_r <= cr1_nxt; cnt_r <= cnt_nxt; ccr_r <= ccr_nxt; arr_r <= arr_nxt;
      ph_r <= ph_nxt; sr_r <= sr_nxt; rd_r <= rd_nxt; dier_r <= dier_nxt;
      if (wr && off_r == OFF_CR2)  cr2_r <= data_r;
      if (wr && off_r == OFF_CCMR) ccmr_r <= data_r;
      if (wr && off_r == OFF_PSC)  psc_r <= data_r[15:0];
      // request uses flags and enables after this word
      if ((sr_nxt & dier_nxt[1:0]) != '0) begin
        pulse_r <= !armed_r;
        armed_r <= 1'b1;
      end else begin
        pulse_r <= 1'b0;
        armed_r <= 1'b0;
      end
    end
  end

  assign out_read_data = rd_r;
  assign out_irq_pulse = pulse_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.exec) && $past(op_r) == OP_TICK |-> cnt_r <= arr_r || $past(cnt_r) > $past(arr_r))
    else $error("counter beyond reload");
  a_pulse_armed: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_r |-> armed_r) else $error("pulse without arm");
  a_rem_small: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_done |-> rem_r < dvs_r) else $error("bad remainder");
endmodule

/* rtl/timer_with_compare_and_reload.sv */
// Top level of the timer with compare and reload.
// Depends on tcr_pkg, tcr_ctrl, tcr_dp.
//   channel  direction  ports
//   in       input      in_valid/in_ready, opcode, reg_offset, write_data, size_code
//   out      output     out_valid/out_ready, read_data, irq_pulse
// Ticks, reads and other writes pass through the EXEC and OUT states before out_valid.
// CNT and ARR writes first run a bit-serial modulo, one bit a cycle, in the DIV state.
// One word in flight; in_ready is low until the result is taken.
// rst_n is synchronous: reload resets to all ones, the other timer registers to zero.
`timescale 1ns / 1ps
module timer_with_compare_and_reload import tcr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_reg_offset,
  input  logic [31:0] in_write_data,
  input  logic [1:0]  in_size_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_irq_pulse
);
  tcr_cmd_t cmd;
  tcr_sts_t sts;
  logic load;

  tcr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .load(load), .cmd(cmd), .sts(sts)
  );

  tcr_dp u_dp (
    .clk(clk), .rst_n(rst_n), .load(load), .in_opcode(in_opcode),
    .in_reg_offset(in_reg_offset), .in_write_data(in_write_data),
    .in_size_code(in_size_code), .cmd(cmd), .sts(sts),
    .out_read_data(out_read_data), .out_irq_pulse(out_irq_pulse)
  );
endmodule
